>>> src/rtt_pkg.sv
// rtt_pkg: shared constants, types and register codes of the rsi threshold trader
// used by rtt_cfg and rsi_threshold_trader_core
// no dependencies
package rtt_pkg;

    // default ring depth and field widths
    localparam int MAX_WINDOW_DEF = 256;
    localparam int PRICE_W        = 32;
    localparam int CHANGE_W       = PRICE_W + 1;
    localparam int RSI_W          = 15;
    localparam int POS_W          = 16;
    localparam int MONEY_W        = 64;
    localparam int WL_W           = 9;
    localparam int LIMIT_W        = 15;
    localparam int LEVEL_W        = 15;
    localparam int EW             = WL_W + 1;
    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;
    localparam int TDATA_W        = 168;

    // rsi full scale: 100 percent in q7.8
    localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 15'd25600;

    // register reset values
    localparam logic [WL_W-1:0]    WL_RESET    = 9'd14;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd5;
    localparam logic [LEVEL_W-1:0] OB_RESET    = 15'd17920;
    localparam logic [LEVEL_W-1:0] OS_RESET    = 15'd7680;

    // trade codes on the result stream
    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

    // register index, byte address / 4
    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH    = 2'd0,
        REG_POSITION_LIMIT   = 2'd1,
        REG_OVERBOUGHT_LEVEL = 2'd2,
        REG_OVERSOLD_LEVEL   = 2'd3
    } reg_index_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [WL_W-1:0]    window_length;
        logic [LIMIT_W-1:0] position_limit;
        logic [LEVEL_W-1:0] overbought_level;
        logic [LEVEL_W-1:0] oversold_level;
    } cfg_regs_t;

endpackage

>>> src/rtt_cfg.sv
// rtt_cfg: apb register bank for window length, position limit and rsi levels
// depends on rtt_pkg; signals a window restart on a window length write
module rtt_cfg
    import rtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_regs_t         cfg,
    output logic              restart
);

    cfg_regs_t  cfg_reg;
    cfg_regs_t  cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign index   = reg_index_t'(paddr[APB_AW-1:2]);
    assign cfg     = cfg_reg;
    assign restart = wr_en && (index == REG_WINDOW_LENGTH);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_WINDOW_LENGTH:    cfg_next.window_length    = pwdata[WL_W-1:0];
                REG_POSITION_LIMIT:   cfg_next.position_limit   = pwdata[LIMIT_W-1:0];
                REG_OVERBOUGHT_LEVEL: cfg_next.overbought_level = pwdata[LEVEL_W-1:0];
                REG_OVERSOLD_LEVEL:   cfg_next.oversold_level   = pwdata[LEVEL_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (index)
            REG_WINDOW_LENGTH:    prdata = APB_DW'(cfg_reg.window_length);
            REG_POSITION_LIMIT:   prdata = APB_DW'(cfg_reg.position_limit);
            REG_OVERBOUGHT_LEVEL: prdata = APB_DW'(cfg_reg.overbought_level);
            REG_OVERSOLD_LEVEL:   prdata = APB_DW'(cfg_reg.oversold_level);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length    <= WL_RESET;
            cfg_reg.position_limit   <= LIMIT_RESET;
            cfg_reg.overbought_level <= OB_RESET;
            cfg_reg.oversold_level   <= OS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/rtt_ring_mem.sv
// rtt_ring_mem: single write port, single read port ring of price changes
// synchronous, registered read; no dependencies
module rtt_ring_mem
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 33
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/rtt_divider.sv
// rtt_divider: restoring divider, one quotient bit per cycle
// quotient must fit in QW bits (num < den << QW); depends on nothing
module rtt_divider
#(
    parameter int NUM_W = 55,
    parameter int DEN_W = 40,
    parameter int QW    = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QW-1:0]    quotient
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] rem_next;
    logic [NUM_W-1:0] dsh_reg;
    logic [NUM_W-1:0] dsh_next;
    logic [QW-1:0]    q_reg;
    logic [QW-1:0]    q_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic             fits;

    assign done     = done_reg;
    assign quotient = q_reg;
    assign fits     = (rem_reg >= dsh_reg);

    // one trial subtract per cycle, divisor walks right
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (QW - 1);
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QW-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

endmodule

>>> src/rsi_threshold_trader_core.sv
// rsi_threshold_trader_core: rsi threshold trader around a ring memory of price changes
// depends on rtt_pkg, rtt_cfg, rtt_ring_mem and rtt_divider
//
//  channel   direction  transfer                        payload
//  s_*       in         s_tvalid & s_tready             s_tdata: price
//  m_*       out        m_tvalid & m_tready             m_tdata, m_tuser: one result
//  apb       in         psel & penable & pwrite (write)  pwdata: register at 4*index
//
// steps: the first price after reset or window restart is only recorded; a price that
//   fills the window without a result passes remove and add; a result passes remove, add,
//   scale, the 15 step divider for the rsi ratio, trade, mark and out; a flat window skips the divider
// each item issues the ring read of the oldest change on acceptance, uses it in the
//   cycle after and writes the new change back in that cycle; one item is in flight at a time
// reset clears sums, pointer, position and balance; ring entries are read only after
//   being written, so the memory needs no clearing pass
// the output register decouples the sides: a new price is taken while a result waits,
//   and only the final load stalls on m_tready
module rsi_threshold_trader_core
    import rtt_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] price
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [1:0] action, [16:2] rsi_value,
                                          // [32:17] position, [96:33] balance,
                                          // [160:97] marked_value, rest zero
    output logic [0:0]         m_tuser,   // [0] flat_window
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IW      = ((AW > EW) ? AW : EW) + 1;
    localparam int WIN_CAP = (MAX_WINDOW < (1 << WL_W) - 1) ? MAX_WINDOW : (1 << WL_W) - 1;
    localparam int SUM_W   = PRICE_W + $clog2(WIN_CAP);
    localparam int NUM_W   = SUM_W + RSI_W;
    localparam int PROD_W  = POS_W + CHANGE_W;

    localparam logic signed [MONEY_W-1:0] MONEY_MAX = {1'b0, {(MONEY_W-1){1'b1}}};
    localparam logic signed [MONEY_W-1:0] MONEY_MIN = {1'b1, {(MONEY_W-1){1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_REMOVE = 8'b0000_0010,
        S_ADD    = 8'b0000_0100,
        S_SCALE  = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_TRADE  = 8'b0010_0000,
        S_MARK   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    // saturating add onto a 64 bit money value
    function automatic logic signed [MONEY_W-1:0] sat_add(
        input logic signed [MONEY_W-1:0] a,
        input logic signed [MONEY_W:0]   b
    );
        logic signed [MONEY_W+1:0] s;
        s = (MONEY_W+2)'(a) + (MONEY_W+2)'(b);
        if (s > (MONEY_W+2)'(MONEY_MAX))
            return MONEY_MAX;
        else if (s < (MONEY_W+2)'(MONEY_MIN))
            return MONEY_MIN;
        else
            return s[MONEY_W-1:0];
    endfunction

    cfg_regs_t cfg;
    logic      cfg_restart;

    state_t                      state_reg, state_next;
    logic [PRICE_W-1:0]          price_reg, price_next;
    logic [PRICE_W-1:0]          prev_reg, prev_next;
    logic [CHANGE_W-1:0]         change_reg, change_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [EW-1:0]               seen_reg, seen_next;
    logic [SUM_W-1:0]            gain_reg, gain_next;
    logic [SUM_W-1:0]            loss_reg, loss_next;
    logic                        due_reg, due_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [NUM_W-1:0]            num_reg, num_next;
    logic                        flat_reg, flat_next;
    logic [RSI_W-1:0]            rsi_reg, rsi_next;
    action_t                     action_reg, action_next;
    logic signed [POS_W-1:0]     held_reg, held_next;
    logic signed [MONEY_W-1:0]   cash_reg, cash_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        div_start_reg, div_start_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]          m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    logic [EW-1:0]               eff_w;
    logic [IW-1:0]               old_diff;
    logic [AW-1:0]               old_idx;
    logic                        accept;
    logic                        was_full;
    logic                        mem_wr_en;
    logic [CHANGE_W-1:0]         mem_rdata;
    logic [CHANGE_W-1:0]         old_neg;
    logic [CHANGE_W-1:0]         new_neg;
    logic                        div_done;
    logic [RSI_W-1:0]            div_q;
    logic signed [POS_W+1:0]     held_x;
    logic signed [POS_W+1:0]     limit_x;
    logic signed [MONEY_W:0]     price_x;
    logic signed [MONEY_W-1:0]   marked;

    rtt_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (cfg_restart)
    );

    rtt_ring_mem
    #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW),
        .DW    (CHANGE_W)
    )
    u_ring
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (change_reg),
        .rd_en   (accept),
        .rd_addr (old_idx),
        .rd_data (mem_rdata)
    );

    rtt_divider
    #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W),
        .QW    (RSI_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .num      (num_reg),
        .den      (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // effective window: zero counts as one, clamp to ring depth
    always_comb
    begin
        if (cfg.window_length == '0)
            eff_w = EW'(1);
        else if (32'(cfg.window_length) > 32'(MAX_WINDOW))
            eff_w = EW'(MAX_WINDOW);
        else
            eff_w = EW'(cfg.window_length);
    end

    // slot of the change that leaves the window
    always_comb
    begin
        old_diff = IW'(ptr_reg) - IW'(eff_w);
        if (old_diff[IW-1])
            old_diff = old_diff + IW'(MAX_WINDOW);
        old_idx = old_diff[AW-1:0];
    end

    assign s_tready = (state_reg == S_IDLE) && !cfg_restart;
    assign accept   = s_tvalid && s_tready;
    assign was_full = ({1'b0, seen_reg} >= ({1'b0, eff_w} + (EW+1)'(1)));
    assign old_neg  = -mem_rdata;
    assign new_neg  = -change_reg;
    assign held_x   = (POS_W+2)'(held_reg);
    assign limit_x  = $signed((POS_W+2)'(cfg.position_limit));
    assign price_x  = $signed((MONEY_W+1)'(price_reg));
    assign marked   = sat_add(cash_reg, (MONEY_W+1)'(prod_reg));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // sequencer: read old change, write back new, update sums, divide, trade, mark and output
    always_comb
    begin
        state_next     = state_reg;
        price_next     = price_reg;
        prev_next      = prev_reg;
        change_next    = change_reg;
        ptr_next       = ptr_reg;
        seen_next      = seen_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        due_next       = due_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        flat_next      = flat_reg;
        rsi_next       = rsi_reg;
        action_next    = action_reg;
        held_next      = held_reg;
        cash_next      = cash_reg;
        prod_next      = prod_reg;
        div_start_next = 1'b0;
        mem_wr_en      = 1'b0;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        // output register drains on the consumer side
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    price_next = s_tdata;
                    prev_next  = s_tdata;
                    if (seen_reg == '0)
                    begin
                        seen_next = EW'(1);
                    end
                    else
                    begin
                        change_next = {1'b0, s_tdata} - {1'b0, prev_reg};
                        state_next  = S_REMOVE;
                    end
                end
            end
            S_REMOVE:
            begin
                // drop the oldest change once the window is full
                if (was_full)
                begin
                    if (!mem_rdata[CHANGE_W-1] && (mem_rdata != '0))
                        gain_next = gain_reg - SUM_W'(mem_rdata[PRICE_W-1:0]);
                    else if (mem_rdata[CHANGE_W-1])
                        loss_next = loss_reg - SUM_W'(old_neg[PRICE_W-1:0]);
                end
                else
                begin
                    seen_next = seen_reg + 1'b1;
                end
                due_next   = was_full || (seen_reg == eff_w);
                mem_wr_en  = 1'b1;
                ptr_next   = (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (!change_reg[CHANGE_W-1] && (change_reg != '0))
                    gain_next = gain_reg + SUM_W'(change_reg[PRICE_W-1:0]);
                else if (change_reg[CHANGE_W-1])
                    loss_next = loss_reg + SUM_W'(new_neg[PRICE_W-1:0]);
                state_next = due_reg ? S_SCALE : S_IDLE;
            end
            S_SCALE:
            begin
                sum_next  = gain_reg + loss_reg;
                num_next  = NUM_W'(gain_reg) * NUM_W'(RSI_FULL_SCALE);
                flat_next = (gain_reg == '0) && (loss_reg == '0);
                if (flat_next)
                begin
                    rsi_next   = '0;
                    state_next = S_TRADE;
                end
                else
                begin
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rsi_next   = div_q;
                    state_next = S_TRADE;
                end
            end
            S_TRADE:
            begin
                action_next = ACT_HOLD;
                if (!flat_reg && (rsi_reg > cfg.overbought_level) && (held_x > -limit_x))
                begin
                    action_next = ACT_SELL;
                    held_next   = held_reg - 1'b1;
                    cash_next   = sat_add(cash_reg, price_x);
                end
                else if (!flat_reg && (rsi_reg < cfg.oversold_level) && (held_x < limit_x))
                begin
                    action_next = ACT_BUY;
                    held_next   = held_reg + 1'b1;
                    cash_next   = sat_add(cash_reg, -price_x);
                end
                state_next = S_MARK;
            end
            S_MARK:
            begin
                prod_next  = PROD_W'(held_reg) * PROD_W'($signed({1'b0, price_reg}));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'({marked, cash_reg, held_reg, rsi_reg, action_reg});
                    m_tuser_next  = flat_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // window length write restarts the window
        if (cfg_restart)
        begin
            ptr_next  = '0;
            seen_next = '0;
            gain_next = '0;
            loss_next = '0;
        end
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            gain_reg      <= '0;
            loss_reg      <= '0;
            due_reg       <= 1'b0;
            held_reg      <= '0;
            cash_reg      <= '0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            ptr_reg       <= ptr_next;
            seen_reg      <= seen_next;
            gain_reg      <= gain_next;
            loss_reg      <= loss_next;
            due_reg       <= due_next;
            held_reg      <= held_next;
            cash_reg      <= cash_next;
            div_start_reg <= div_start_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        price_reg   <= price_next;
        change_reg  <= change_next;
        sum_reg     <= sum_next;
        num_reg     <= num_next;
        flat_reg    <= flat_next;
        rsi_reg     <= rsi_next;
        action_reg  <= action_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // window restart leaves an empty window
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> (seen_reg == '0 && gain_reg == '0 && loss_reg == '0 && ptr_reg == '0))
        else $error("window restart did not clear the window state");

    // prices counted never exceed the window plus the first price
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, seen_reg} <= ({1'b0, eff_w} + (EW+1)'(1))))
        else $error("prices seen ran past the window");

    // divider finishes only while the sequencer waits for it
    a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider result outside the divide step");

    // a flat window gives rsi zero and no trade
    a_flat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tuser_reg) |->
            (m_tdata_reg[1:0] == ACT_HOLD && m_tdata_reg[16:2] == '0))
        else $error("flat window result carries a trade or nonzero rsi");

endmodule

>>> tb/tb_rsi_threshold_trader_core.sv
// tb_rsi_threshold_trader_core: self-checking bench for the rsi threshold trader core
// predicts every trade result from the prices it sends and checks the result stream
// depends on rtt_pkg and rsi_threshold_trader_core
`timescale 1ns / 100ps

module tb_rsi_threshold_trader_core
    import rtt_pkg::*;
();

    localparam int RING_DEPTH     = MAX_WINDOW_DEF;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_BURST    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    // expected content of one result transaction
    typedef struct {
        action_t                   action;
        logic [RSI_W-1:0]          rsi;
        logic                      flat;
        logic signed [POS_W-1:0]   position;
        logic signed [MONEY_W-1:0] balance;
        logic signed [MONEY_W-1:0] marked;
    } trade_t;

    // shapes of price runs
    typedef enum int {
        PM_WALK,
        PM_RISE,
        PM_FALL,
        PM_STEADY,
        PM_SCATTER,
        PM_SWING
    } price_mode_t;

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;   // [31:0] price
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // [1:0] action, [16:2] rsi_value,
                                         // [32:17] position, [96:33] balance,
                                         // [160:97] marked_value, rest zero
    logic [0:0]         m_tuser;         // [0] flat_window
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [APB_AW-1:0]  paddr    = '0;
    logic [APB_DW-1:0]  pwdata   = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // stimulus and scoreboard
    logic [31:0] price_queue[$];
    trade_t      expected_trades[$];
    int          prices_sent   = 0;
    int          prices_taken  = 0;
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        stall_burst_req = 1'b0;
    int          stall_burst_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] gen_price;

    // predictor copy of the configuration
    logic [WL_W-1:0]    cfg_window = WL_RESET;
    logic [LIMIT_W-1:0] cfg_limit  = LIMIT_RESET;
    logic [LEVEL_W-1:0] cfg_ob     = OB_RESET;
    logic [LEVEL_W-1:0] cfg_os     = OS_RESET;

    // predictor copy of the trading state
    longint          change_ring[RING_DEPTH];
    int unsigned     ring_ptr   = 0;
    longint          last_price = 0;
    longint unsigned gain_tally = 0;
    longint unsigned loss_tally = 0;
    int unsigned     seen_count = 0;
    int              held       = 0;
    longint          cash       = 0;

    rsi_threshold_trader_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // signed add clipped to the 64-bit range
    function automatic longint sat_sum(input longint a, input longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    function automatic void restart_window();
        ring_ptr   = 0;
        gain_tally = 0;
        loss_tally = 0;
        seen_count = 0;
    endfunction

    // advance the trading state by one price, queue the trade it produces
    function automatic void predict_trade(input logic [31:0] price);
        trade_t          t;
        int unsigned     w;
        longint          price_l;
        longint          chg;
        longint          oldc;
        longint unsigned sum;
        longint unsigned ratio;
        w = (cfg_window == 0) ? 1 : ((cfg_window > RING_DEPTH) ? RING_DEPTH : cfg_window);
        price_l = longint'(price);
        if (seen_count == 0)
        begin
            last_price = price_l;
            seen_count = 1;
            return;
        end
        chg = price_l - last_price;
        last_price = price_l;

        // drop the change leaving the window
        if (seen_count >= w + 1)
        begin
            oldc = change_ring[(ring_ptr + RING_DEPTH - w) % RING_DEPTH];
            if (oldc > 0)
                gain_tally -= oldc;
            else if (oldc < 0)
                loss_tally -= -oldc;
        end
        else
            seen_count++;

        change_ring[ring_ptr] = chg;
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        if (chg > 0)
            gain_tally += chg;
        else if (chg < 0)
            loss_tally += -chg;
        if (seen_count < w + 1)
            return;

        // rsi and the trade decision
        t.action = ACT_HOLD;
        t.rsi    = '0;
        t.flat   = 1'b0;
        sum = gain_tally + loss_tally;
        if (sum == 0)
            t.flat = 1'b1;
        else
        begin
            ratio = (gain_tally * RSI_FULL_SCALE) / sum;
            t.rsi = ratio[RSI_W-1:0];
            if (ratio > cfg_ob && held > -int'(cfg_limit))
            begin
                t.action = ACT_SELL;
                held--;
                cash = sat_sum(cash, price_l);
            end
            else if (ratio < cfg_os && held < int'(cfg_limit))
            begin
                t.action = ACT_BUY;
                held++;
                cash = sat_sum(cash, -price_l);
            end
        end
        t.position = held[POS_W-1:0];
        t.balance  = cash;
        t.marked   = sat_sum(cash, longint'(held) * price_l);
        expected_trades = {expected_trades, t};
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint got_v);
        if (exp_v !== got_v)
        begin
            error_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
        end
    endfunction

    // sender: one price transaction at a time from the price queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_trade(s_tdata);
                prices_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (price_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= price_queue.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready with random stalls and one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready         <= 1'b0;
            stall_burst_left <= 0;
        end
        else if (stall_burst_req)
        begin
            stall_burst_req  <= 1'b0;
            stall_burst_left <= STALL_BURST;
            m_tready         <= 1'b0;
        end
        else if (stall_burst_left != 0)
        begin
            stall_burst_left <= stall_burst_left - 1;
            m_tready         <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        trade_t t;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_trades.size() == 0)
            begin
                error_count++;
                $display("%0t: result transaction expected none got data %h flat %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                t = expected_trades.pop_front();
                check_field("action", t.action, m_tdata[1:0]);
                check_field("rsi_value", t.rsi, m_tdata[16:2]);
                check_field("flat_window", t.flat, m_tuser[0]);
                check_field("position", t.position, $signed(m_tdata[32:17]));
                check_field("balance", t.balance, $signed(m_tdata[96:33]));
                check_field("marked_value", t.marked, $signed(m_tdata[160:97]));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_rsi_threshold_trader_core NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic offer(input logic [31:0] price);
        price_queue = {price_queue, price};
        prices_sent++;
    endtask

    // wait until every price is taken and every result has arrived, then settle
    task automatic wait_idle();
        while (prices_taken != prices_sent || expected_trades.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write followed by a read back
    task automatic set_reg(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] stored;
        stored = (idx == REG_WINDOW_LENGTH) ? (value & 32'h1FF) : (value & 32'h7FFF);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WINDOW_LENGTH:
            begin
                cfg_window = stored[WL_W-1:0];
                restart_window();
            end
            REG_POSITION_LIMIT:   cfg_limit = stored[LIMIT_W-1:0];
            REG_OVERBOUGHT_LEVEL: cfg_ob    = stored[LEVEL_W-1:0];
            REG_OVERSOLD_LEVEL:   cfg_os    = stored[LEVEL_W-1:0];
            default:              ;
        endcase
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
        begin
            error_count++;
            $display("%0t: register %s read expected %0d got %0d",
                     $time, idx.name(), stored, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] next_price(input price_mode_t mode, input logic [31:0] prev);
        longint p;
        p = longint'(prev);
        case (mode)
            PM_WALK:    p += longint'($urandom_range(0, 2000)) - 1000;
            PM_RISE:    p += longint'($urandom_range(0, 4000)) - 500;
            PM_FALL:    p -= longint'($urandom_range(0, 4000)) - 500;
            PM_STEADY:  ;
            PM_SCATTER:
                case ($urandom_range(7))
                    0:       p = 0;
                    1:       p = 64'sh0_FFFF_FFFF;
                    default: p = longint'($urandom());
                endcase
            PM_SWING:   p += longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
            default:    ;
        endcase
        if (p < 0)
            p = 0;
        else if (p > 64'sh0_FFFF_FFFF)
            p = 64'sh0_FFFF_FFFF;
        return p[31:0];
    endfunction

    // runs of trending, flat and scattered prices
    task automatic queue_prices(input int count);
        int          left;
        int          run;
        price_mode_t mode;
        left = count;
        while (left > 0)
        begin
            case ($urandom_range(9))
                0, 1, 2: mode = PM_WALK;
                3, 4:    mode = PM_RISE;
                5, 6:    mode = PM_FALL;
                7:       mode = PM_STEADY;
                8:       mode = PM_SCATTER;
                default: mode = PM_SWING;
            endcase
            run = $urandom_range(3, 30);
            if (run > left)
                run = left;
            repeat (run)
            begin
                gen_price = next_price(mode, gen_price);
                offer(gen_price);
            end
            left -= run;
        end
    endtask

    initial
    begin
        int phase;
        int count;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // one-change window, limit of one: extreme prices, flat window, limit blocking
        set_reg(REG_WINDOW_LENGTH, 1);
        set_reg(REG_POSITION_LIMIT, 1);
        set_reg(REG_OVERBOUGHT_LEVEL, 17920);
        set_reg(REG_OVERSOLD_LEVEL, 7680);
        offer(32'd0);
        offer(32'hFFFF_FFFF);
        offer(32'hFFFF_FFFF);
        offer(32'd0);
        offer(32'd0);
        offer(32'd5);
        offer(32'd10);
        offer(32'd3);
        offer(32'd1);
        offer(32'd0);
        wait_idle();

        // zero window acts as one, zero limit still allows closing a long
        set_reg(REG_WINDOW_LENGTH, 0);
        set_reg(REG_POSITION_LIMIT, 0);
        offer(32'd100);
        offer(32'd200);
        offer(32'd50);
        offer(32'd50);
        wait_idle();

        // full-scale levels: steady buying, then a limit below the held position
        set_reg(REG_WINDOW_LENGTH, 2);
        set_reg(REG_POSITION_LIMIT, 32767);
        set_reg(REG_OVERBOUGHT_LEVEL, 25600);
        set_reg(REG_OVERSOLD_LEVEL, 25600);
        offer(32'd10);
        offer(32'd9);
        offer(32'd8);
        offer(32'd7);
        offer(32'd6);
        wait_idle();
        set_reg(REG_POSITION_LIMIT, 1);
        offer(32'd5);
        offer(32'd6);
        wait_idle();
        set_reg(REG_OVERBOUGHT_LEVEL, 0);
        offer(32'd7);
        offer(32'd8);
        wait_idle();

        // random phases with varied idling and settings
        gen_price = $urandom_range(1000, 1000000);
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            count = 50;
            if (phase == 6)
            begin
                set_reg(REG_WINDOW_LENGTH, 256);
                count = 280;
            end
            else if (phase == 11)
            begin
                // beyond the ring depth, clamped by the block
                set_reg(REG_WINDOW_LENGTH, 300);
                count = 280;
            end
            else if (phase % 3 != 2)
                set_reg(REG_WINDOW_LENGTH, $urandom_range(1, 16));
            case ($urandom_range(4))
                0:       set_reg(REG_POSITION_LIMIT, 0);
                1:       set_reg(REG_POSITION_LIMIT, 32767);
                default: set_reg(REG_POSITION_LIMIT, $urandom_range(1, 6));
            endcase
            if (phase == 3)
            begin
                set_reg(REG_OVERBOUGHT_LEVEL, 25600);
                set_reg(REG_OVERSOLD_LEVEL, 0);
            end
            else
            begin
                set_reg(REG_OVERBOUGHT_LEVEL, $urandom_range(12800, 25600));
                set_reg(REG_OVERSOLD_LEVEL, $urandom_range(0, 12800));
            end
            // long receiver hold-off while prices keep coming
            if (phase == 0)
                stall_burst_req <= 1'b1;
            queue_prices(count);
            wait_idle();
        end

        if (error_count == 0)
            $display("tb_rsi_threshold_trader_core OK");
        else
            $display("tb_rsi_threshold_trader_core NOT OK");
        $finish;
    end

endmodule
